FILE: src/abb_pkg.sv
// Package for the anchored box blur: sizes, register indexes, command and status types.
// No dependencies.
`timescale 1ns / 1ps
package abb_pkg;
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_WINDOW = 32;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int KW = $clog2(MAX_WINDOW);
   localparam int SW = 19;                 // one channel's vertical sum
   localparam int TW = 24;                 // one channel's window total
   localparam int CW = 11;                 // covered pixel count

   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef struct packed {
      logic load;      // capture pixel and position, start reads
      logic update;    // write column sum, rows and recent sum
      logic acc_clr;   // clear horizontal total
      logic acc_add;   // add one recent column sum
      logic div_start;
   } cmd_type;

   typedef struct packed {
      logic acc_done;
      logic div_done;
   } status_type;
endpackage

FILE: src/abb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module abb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: src/abb_datapath.sv
// Datapath: line buffers, column sums, horizontal accumulation and divider.
// Depends on abb_pkg and abb_ram.
`timescale 1ns / 1ps
module abb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  abb_pkg::cmd_type    cmd,
   output abb_pkg::status_type status,
   input  logic [7:0]          px_b,
   input  logic [7:0]          px_g,
   input  logic [7:0]          px_r,
   input  logic [abb_pkg::XW-1:0] pos_x,
   input  logic [abb_pkg::YW-1:0] pos_y,
   input  logic [abb_pkg::XW:0]   w,
   input  logic [abb_pkg::YW:0]   h,
   input  logic [abb_pkg::KW:0]   k,
   output logic [7:0]          q_b,
   output logic [7:0]          q_g,
   output logic [7:0]          q_r,
   output logic                last_px
);
   localparam int RA = abb_pkg::KW + abb_pkg::XW;
   localparam int S3 = 3 * abb_pkg::SW;

   logic [23:0] pix_ff;
   logic [abb_pkg::XW-1:0] x_ff;
   logic [abb_pkg::YW-1:0] y_ff;
   logic [abb_pkg::KW-1:0] yo_ff;
   logic first_ff, drop_ff, last_ff;
   logic [abb_pkg::CW-1:0] count_ff;
   logic [abb_pkg::KW:0] cw_ff;

   logic [abb_pkg::XW:0] x_in;
   logic [abb_pkg::YW:0] y_in;
   logic [abb_pkg::YW+1:0] yk;
   assign x_in = w - 1'b1 - {1'b0, pos_x};
   assign y_in = h - 1'b1 - {1'b0, pos_y};
   assign yk   = {1'b0, y_in} + {{(abb_pkg::YW+1-abb_pkg::KW){1'b0}}, k};

   // Reads are issued from the registered position in the cycle after the transfer,
   // so their data is ready in the cycle that writes the update.
   logic [23:0] old_px;
   logic [S3-1:0] col_rd, rec_rd;
   logic [RA-1:0] rd_addr, wr_addr;
   assign rd_addr = {yo_ff, x_ff};
   assign wr_addr = {y_ff[abb_pkg::KW-1:0], x_ff};

   // Vertical sum for the column: add the new pixel, drop the row leaving the window.
   logic [S3-1:0] col_new;
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col_new[c*abb_pkg::SW +: abb_pkg::SW] =
            (first_ff ? '0 : col_rd[c*abb_pkg::SW +: abb_pkg::SW])
            + abb_pkg::SW'(pix_ff[c*8 +: 8])
            - (drop_ff ? abb_pkg::SW'(old_px[c*8 +: 8]) : '0);
      end
   end

   abb_ram #(.WIDTH(24), .DEPTH(abb_pkg::MAX_WINDOW * abb_pkg::MAX_WIDTH)) u_rows (
      .clock, .wr_en(cmd.update), .wr_addr, .wr_data(pix_ff),
      .rd_addr, .rd_data(old_px));
   abb_ram #(.WIDTH(S3), .DEPTH(abb_pkg::MAX_WIDTH)) u_cols (
      .clock, .wr_en(cmd.update), .wr_addr(x_ff), .wr_data(col_new),
      .rd_addr(x_ff), .rd_data(col_rd));

   // Recent column sums of this row, read one a cycle during accumulation.
   logic [abb_pkg::KW:0] j_ff;
   logic [abb_pkg::KW-1:0] rec_addr;
   logic [abb_pkg::KW-1:0] xk;
   assign xk = x_ff[abb_pkg::KW-1:0];
   assign rec_addr = xk + j_ff[abb_pkg::KW-1:0];
   abb_ram #(.WIDTH(S3), .DEPTH(abb_pkg::MAX_WINDOW)) u_recent (
      .clock, .wr_en(cmd.update), .wr_addr(xk), .wr_data(col_new),
      .rd_addr(rec_addr), .rd_data(rec_rd));

   logic [abb_pkg::XW:0] wx;
   logic [abb_pkg::YW:0] hy;
   logic [abb_pkg::KW:0] cw_in, ch_in;
   assign wx = w - x_in;
   assign hy = h - y_in;
   assign cw_in = (wx < {{(abb_pkg::XW-abb_pkg::KW){1'b0}}, k}) ? wx[abb_pkg::KW:0] : k;
   assign ch_in = (hy < {{(abb_pkg::YW-abb_pkg::KW){1'b0}}, k}) ? hy[abb_pkg::KW:0] : k;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff   <= {px_r, px_g, px_b};
         x_ff     <= x_in[abb_pkg::XW-1:0];
         y_ff     <= y_in[abb_pkg::YW-1:0];
         yo_ff    <= yk[abb_pkg::KW-1:0];
         first_ff <= (pos_y == '0);
         drop_ff  <= (yk < {1'b0, h});
         last_ff  <= (x_in == '0) && (y_in == '0);
         cw_ff    <= cw_in;
         count_ff <= abb_pkg::CW'(cw_in * ch_in);
      end
   end

   // Accumulation: issue reads j = 0..cw-1, sum their data in the cycle after each read.
   logic [3*abb_pkg::TW-1:0] tot_ff;
   logic rv_ff;
   logic acc_busy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0; rv_ff <= 1'b0; acc_busy_ff <= 1'b0;
      end else if (cmd.acc_clr) begin
         j_ff <= '0; rv_ff <= 1'b0; acc_busy_ff <= 1'b1;
      end else if (acc_busy_ff) begin
         rv_ff <= (j_ff < cw_ff);
         if (j_ff < cw_ff) j_ff <= j_ff + 1'b1;
         else if (!rv_ff) acc_busy_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.acc_clr) tot_ff <= '0;
      else if (acc_busy_ff && rv_ff) begin
         for (int c = 0; c < 3; c++)
            tot_ff[c*abb_pkg::TW +: abb_pkg::TW] <= tot_ff[c*abb_pkg::TW +: abb_pkg::TW]
               + abb_pkg::TW'(rec_rd[c*abb_pkg::SW +: abb_pkg::SW]);
      end
   end
   assign status.acc_done = acc_busy_ff && (j_ff >= cw_ff) && !rv_ff;

   // Restoring divider, one quotient bit per cycle, three channels side by side.
   localparam int NB = abb_pkg::TW;
   logic [NB-1:0] rem_ff [3];
   logic [NB-1:0] num_ff [3];
   logic [$clog2(NB+1)-1:0] cnt_ff;
   logic div_busy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0; cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1; cnt_ff <= '0;
      end else if (div_busy_ff) begin
         if (cnt_ff == ($clog2(NB+1))'(NB)) div_busy_ff <= 1'b0;
         else cnt_ff <= cnt_ff + 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.div_start) begin
            rem_ff[c] <= '0;
            num_ff[c] <= tot_ff[c*NB +: NB];
         end else if (div_busy_ff && cnt_ff != ($clog2(NB+1))'(NB)) begin
            logic [NB:0] t;
            t = {rem_ff[c], num_ff[c][NB-1]};
            if (t >= (NB+1)'(count_ff)) begin
               rem_ff[c] <= NB'(t - (NB+1)'(count_ff));
               num_ff[c] <= {num_ff[c][NB-2:0], 1'b1};
            end else begin
               rem_ff[c] <= t[NB-1:0];
               num_ff[c] <= {num_ff[c][NB-2:0], 1'b0};
            end
         end
      end
   end
   assign status.div_done = div_busy_ff && (cnt_ff == ($clog2(NB+1))'(NB));
   assign q_b = num_ff[0][7:0];
   assign q_g = num_ff[1][7:0];
   assign q_r = num_ff[2][7:0];
   assign last_px = last_ff;
endmodule

FILE: src/abb_ctrl.sv
// Controller state machine: sequences load, update, accumulate, divide, respond.
// Depends on abb_pkg.
`timescale 1ns / 1ps
module abb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                restart,
   output abb_pkg::cmd_type    cmd,
   input  abb_pkg::status_type status,
   input  logic [abb_pkg::XW:0] w,
   input  logic [abb_pkg::YW:0] h,
   output logic [abb_pkg::XW-1:0] pos_x,
   output logic [abb_pkg::YW-1:0] pos_y
);
   localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_UPD = 3'd2, S_ACC = 3'd3,
                          S_DIV = 3'd4, S_OUT = 3'd5;
   logic [2:0] state_ff, state_in;
   logic [abb_pkg::XW:0] px_ff;
   logic [abb_pkg::YW:0] py_ff;

   // Positions are clamped as in a fresh row or frame when the limits shrink.
   logic [abb_pkg::XW:0] px_c;
   logic [abb_pkg::YW:0] py_c;
   assign px_c = (px_ff >= w) ? '0 : px_ff;
   assign py_c = (py_ff >= h) ? '0 : py_ff;
   assign pos_x = px_c[abb_pkg::XW-1:0];
   assign pos_y = py_c[abb_pkg::YW-1:0];

   logic take;
   assign req_stall = (state_ff != S_IDLE);
   assign take = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: if (take) begin cmd.load = 1'b1; state_in = S_READ; end
         S_READ: state_in = S_UPD;
         S_UPD: begin cmd.update = 1'b1; state_in = S_ACC; end
         S_ACC: begin
            if (status.acc_done) begin cmd.div_start = 1'b1; state_in = S_DIV; end
         end
         S_DIV: if (status.div_done) state_in = S_OUT;
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // Clear the accumulator in the same cycle as the recent sum is written.
      if (state_ff == S_UPD) cmd.acc_clr = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; px_ff <= '0; py_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (restart) begin
            px_ff <= '0; py_ff <= '0;
         end else if (take) begin
            if (px_c + 1'b1 >= w) begin
               px_ff <= '0;
               py_ff <= (py_c + 1'b1 >= h) ? '0 : py_c + 1'b1;
            end else begin
               px_ff <= px_c + 1'b1;
               py_ff <= py_c;
            end
         end
      end
   end

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !take) else $error("transfer accepted while busy");
   a_load_then_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_READ) else $error("load not followed by read");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped under stall");
endmodule

FILE: src/anchored_box_blur.sv
// Top level of the anchored box blur: configuration registers, controller, datapath.
// Depends on abb_pkg, abb_ctrl and abb_datapath.
// A new pixel is taken only after the previous result has been transferred; the pace is
// set by the serial column-sum walk and the one-bit-per-cycle divider.
// Reset: synchronous, active high; k = 3, width = height = 4096, positions zero.
`timescale 1ns / 1ps
module anchored_box_blur (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_red_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_red_out,
   output logic        rsp_frame_end,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   logic [5:0]  k_ff;
   logic [12:0] w_ff, h_ff;
   logic restart;
   assign restart = csr_write && (csr_index == abb_pkg::REG_WINDOW ||
      csr_index == abb_pkg::REG_WIDTH || csr_index == abb_pkg::REG_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= 6'd3; w_ff <= 13'd4096; h_ff <= 13'd4096;
      end else if (csr_write) begin
         case (csr_index)
            abb_pkg::REG_WINDOW: k_ff <= csr_data[5:0];
            abb_pkg::REG_WIDTH:  w_ff <= csr_data;
            abb_pkg::REG_HEIGHT: h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [abb_pkg::KW:0] k;
   logic [abb_pkg::XW:0] w;
   logic [abb_pkg::YW:0] h;
   assign k = (k_ff == '0) ? (abb_pkg::KW+1)'(1) : (k_ff > 6'(abb_pkg::MAX_WINDOW)) ?
              (abb_pkg::KW+1)'(abb_pkg::MAX_WINDOW) : k_ff[abb_pkg::KW:0];
   assign w = (w_ff == '0) ? (abb_pkg::XW+1)'(1) : (w_ff > 13'(abb_pkg::MAX_WIDTH)) ?
              (abb_pkg::XW+1)'(abb_pkg::MAX_WIDTH) : w_ff[abb_pkg::XW:0];
   assign h = (h_ff == '0) ? (abb_pkg::YW+1)'(1) : (h_ff > 13'(abb_pkg::MAX_HEIGHT)) ?
              (abb_pkg::YW+1)'(abb_pkg::MAX_HEIGHT) : h_ff[abb_pkg::YW:0];

   abb_pkg::cmd_type cmd;
   abb_pkg::status_type status;
   logic [abb_pkg::XW-1:0] pos_x;
   logic [abb_pkg::YW-1:0] pos_y;

   abb_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .restart,
      .cmd, .status, .w, .h, .pos_x, .pos_y);

   abb_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .px_b(req_blue_in), .px_g(req_green_in), .px_r(req_red_in),
      .pos_x, .pos_y, .w, .h, .k,
      .q_b(rsp_blue_out), .q_g(rsp_green_out), .q_r(rsp_red_out),
      .last_px(rsp_frame_end));
endmodule

FILE: tb/anchored_box_blur_test.sv
// Self-checking testbench for anchored_box_blur: random and edge-case pixel streams
// under several window and image sizes, checked against a behavioural predictor.
// Depends on abb_pkg and the anchored_box_blur RTL.
`timescale 1ns / 1ps
module anchored_box_blur_test;
   localparam logic [1:0] REG_SPARE = 2'd3;   // unused index, writes are ignored
   localparam int HOLD_FROM = 6000;
   localparam int HOLD_LEN  = 700;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       last;
   } blurred_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_blue_in = 8'd0;
   logic [7:0]  req_green_in = 8'd0;
   logic [7:0]  req_red_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_blue_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_red_out;
   logic        rsp_frame_end;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [12:0] csr_data = 13'd0;

   anchored_box_blur u_dut (.*);

   // Predictor state.
   logic [5:0]  win_reg;
   logic [12:0] width_reg;
   logic [12:0] height_reg;
   logic [23:0] row_ring [abb_pkg::MAX_WINDOW * abb_pkg::MAX_WIDTH];
   int unsigned col_total [abb_pkg::MAX_WIDTH][3];
   int unsigned near_cols [abb_pkg::MAX_WINDOW][3];
   int unsigned col_pos;
   int unsigned row_pos;

   pixel_type   pending_pixels[$];
   blurred_type expected_pixels[$];
   int          error_count = 0;
   bit          calm = 1'b0;      // no idling on either side while set

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void apply_register(logic [1:0] idx, logic [12:0] value);
      case (idx)
         abb_pkg::REG_WINDOW: win_reg = value[5:0];
         abb_pkg::REG_WIDTH:  width_reg = value;
         abb_pkg::REG_HEIGHT: height_reg = value;
         default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endfunction

   function automatic blurred_type blur_pixel(pixel_type p);
      int unsigned k, w, h, x, y, cw, rh, slot, old_slot, here, total, s;
      bit first_row, drop_row;
      int unsigned chan [3];
      blurred_type r;
      logic [7:0] mean [3];
      k = clip(win_reg, abb_pkg::MAX_WINDOW);
      w = clip(width_reg, abb_pkg::MAX_WIDTH);
      h = clip(height_reg, abb_pkg::MAX_HEIGHT);
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      x = w - 1 - col_pos;
      y = h - 1 - row_pos;
      chan[0] = p.blue;
      chan[1] = p.green;
      chan[2] = p.red;
      first_row = (row_pos == 0);
      drop_row = (y + k < h);
      slot = (y % abb_pkg::MAX_WINDOW) * abb_pkg::MAX_WIDTH + x;
      old_slot = ((y + k) % abb_pkg::MAX_WINDOW) * abb_pkg::MAX_WIDTH + x;
      for (int c = 0; c < 3; c++) begin
         s = first_row ? 0 : col_total[x][c];
         s += chan[c];
         if (drop_row) s -= row_ring[old_slot][c*8 +: 8];
         col_total[x][c] = s;
      end
      row_ring[slot] = {p.red, p.green, p.blue};
      here = x % abb_pkg::MAX_WINDOW;
      for (int c = 0; c < 3; c++) near_cols[here][c] = col_total[x][c];
      cw = (w - x < k) ? (w - x) : k;
      rh = (h - y < k) ? (h - y) : k;
      for (int c = 0; c < 3; c++) begin
         total = 0;
         for (int j = 0; j < cw; j++)
            total += near_cols[(x + j) % abb_pkg::MAX_WINDOW][c];
         mean[c] = 8'(total / (cw * rh));
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      r.blue = mean[0];
      r.green = mean[1];
      r.red = mean[2];
      r.last = (x == 0 && y == 0);
      return r;
   endfunction

   // Driver: offers the oldest pending pixel and predicts it on transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(blur_pixel({req_blue_in, req_green_in, req_red_in}));
            void'(pending_pixels.pop_front());
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (pending_pixels.size() > 0 &&
                      (calm || $urandom_range(99) >= 12)) begin
            req_valid <= 1'b1;
            req_blue_in <= pending_pixels[0].blue;
            req_green_in <= pending_pixels[0].green;
            req_red_in <= pending_pixels[0].red;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer and drives the stall, including one
   // long hold-off that lets the block back up into its input.
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      blurred_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result %h %h %h %b", $time, rsp_blue_out,
                        rsp_green_out, rsp_red_out, rsp_frame_end);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_blue_out !== want.blue) begin
                  $display("%0t: blue expected %h actual %h", $time, want.blue, rsp_blue_out);
                  error_count++;
               end
               if (rsp_green_out !== want.green) begin
                  $display("%0t: green expected %h actual %h", $time, want.green,
                           rsp_green_out);
                  error_count++;
               end
               if (rsp_red_out !== want.red) begin
                  $display("%0t: red expected %h actual %h", $time, want.red, rsp_red_out);
                  error_count++;
               end
               if (rsp_frame_end !== want.last) begin
                  $display("%0t: frame_end expected %b actual %b", $time, want.last,
                           rsp_frame_end);
                  error_count++;
               end
            end
         end
         if (cycle_count >= HOLD_FROM && cycle_count < HOLD_FROM + HOLD_LEN)
            rsp_stall <= 1'b1;
         else
            rsp_stall <= !calm && ($urandom_range(99) < 12);
      end
   end

   task automatic write_register(logic [1:0] idx, logic [12:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      apply_register(idx, value);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain;
      wait (pending_pixels.size() == 0 && !req_valid && expected_pixels.size() == 0);
      // Both queues are empty and no request is offered, so no pixel is left inside the block.
      repeat (80) @(posedge clock);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      p = pixel_type'($urandom);
      if ($urandom_range(9) == 0) p = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      return p;
   endfunction

   task automatic run_phase(int k, int w, int h, int n);
      write_register(abb_pkg::REG_WINDOW, 13'(k));
      write_register(abb_pkg::REG_WIDTH, 13'(w));
      write_register(abb_pkg::REG_HEIGHT, 13'(h));
      for (int i = 0; i < n; i++) pending_pixels.push_back(random_pixel());
      drain();
   endtask

   initial begin
      int sent;
      int k, w, h, n;
      apply_register(abb_pkg::REG_WINDOW, 13'd3);
      apply_register(abb_pkg::REG_WIDTH, 13'd4096);
      apply_register(abb_pkg::REG_HEIGHT, 13'd4096);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration, corner pixel values.
      pending_pixels.push_back(24'h000000);
      pending_pixels.push_back(24'hFFFFFF);
      pending_pixels.push_back(24'h55AA55);
      pending_pixels.push_back(24'hAA55AA);
      drain();
      // Zero sizes read as one: every pixel ends a frame.
      run_phase(0, 0, 0, 3);
      run_phase(1, 3, 2, 6);
      // Oversized window and image saturate.
      run_phase(63, 8191, 8191, 4);
      run_phase(32, 4096, 4096, 4);
      // Ignored index must not restart the frame.
      write_register(abb_pkg::REG_WINDOW, 13'd2);
      write_register(abb_pkg::REG_WIDTH, 13'd3);
      write_register(abb_pkg::REG_HEIGHT, 13'd2);
      pending_pixels.push_back(random_pixel());
      drain();
      write_register(REG_SPARE, 13'h1FFF);
      for (int i = 0; i < 5; i++) pending_pixels.push_back(random_pixel());
      drain();

      // Tall narrow frames wrap the row ring with the largest window.
      run_phase(32, 2, 40, 100);
      calm = 1'b1;
      run_phase(5, 3, 70, 210);
      calm = 1'b0;

      sent = 0;
      while (sent < 1000) begin
         k = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 32);
         w = $urandom_range(1, 40);
         h = $urandom_range(1, 40);
         n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
         if (n > 250) n = 250;
         run_phase(k, w, h, n);
         sent += n;
      end

      if (error_count == 0) begin
         $display("anchored_box_blur_test: clean");
      end else begin
         $display("anchored_box_blur_test: errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("anchored_box_blur_test: errors");
      $finish;
   end
endmodule

FILE: filelist.f
src/abb_pkg.sv
src/abb_ram.sv
src/abb_datapath.sv
src/abb_ctrl.sv
src/anchored_box_blur.sv
tb/anchored_box_blur_test.sv
